FILE: src/spe_pkg.sv
package spe_pkg;

   // Field widths of one transaction on either channel.
   localparam int AC_WIDTH        = 16;
   localparam int DC_WIDTH        = 12;
   localparam int SPO2_WIDTH      = 10;
   localparam int PULSE_WIDTH     = 15;
   localparam int COUNT_WIDTH_DEF = 16;

   // Ratio of ratios in unsigned Q4.12, with its saturation value.
   localparam int FRAC_BITS   = 12;
   localparam int RATIO_WIDTH = 16;
   localparam int SAT_SHIFT   = RATIO_WIDTH - FRAC_BITS;
   localparam int PROD_WIDTH  = AC_WIDTH + DC_WIDTH;
   localparam logic [RATIO_WIDTH-1:0] RATIO_MAX = '1;

   // The ratio and pulse dividers each produce one quotient bit per step.
   localparam int DIV_STEPS  = RATIO_WIDTH;
   localparam int STEP_WIDTH = $clog2(DIV_STEPS);
   localparam int PULSE_NUM  = 30000;

   // Two-piece SpO2 law: below R = 1.0 it is 110 - 25 R, above it 120 - 35.7 R.
   localparam int LAW_WIDTH    = 26;
   localparam int LAW_LO_BASE  = 110 * 4096;
   localparam int LAW_LO_SLOPE = 25;
   localparam int LAW_HI_BASE  = 120 * 10 * 4096;
   localparam int LAW_HI_SLOPE = 357;

   // Division by 40960 is a shift by 13 followed by a reciprocal multiply for 1/5.
   localparam int HI_SHIFT     = 13;
   localparam int MAG_Q_WIDTH  = LAW_WIDTH - 1 - HI_SHIFT;
   localparam int RECIP_WIDTH  = 16;
   localparam int RECIP        = 52429;
   localparam int RECIP_SHIFT  = 18;
   localparam int SCALE_WIDTH  = MAG_Q_WIDTH + RECIP_WIDTH;

   typedef struct packed {
      logic signed [AC_WIDTH-1:0] ac_red;
      logic [DC_WIDTH-1:0]        dc_red;
      logic signed [AC_WIDTH-1:0] ac_ir;
      logic [DC_WIDTH-1:0]        dc_ir;
   } req_type;

   typedef struct packed {
      logic signed [SPO2_WIDTH-1:0] spo2_avg;
      logic [PULSE_WIDTH-1:0]       pulse_avg;
   } rsp_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL   = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_DIV   = 7'b0001000,
      ST_LAW   = 7'b0010000,
      ST_SCALE = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic load;
      logic step;
      logic law;
      logic scale;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic fire;
   } status_type;

endpackage

FILE: src/spe_ctrl.sv
module spe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  spe_pkg::status_type  status,
   output spe_pkg::cmd_type     cmd
);
   import spe_pkg::*;

   state_type             state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;
   logic                  out_free;

   // A new sample is taken only while no crossing is being processed.
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Commands to the datapath, one per sequencer state.
   always_comb begin
      cmd         = '0;
      cmd.capture = accept;
      cmd.mul     = (state_ff == ST_MUL);
      cmd.load    = (state_ff == ST_LOAD);
      cmd.step    = (state_ff == ST_DIV);
      cmd.law     = (state_ff == ST_LAW);
      cmd.scale   = (state_ff == ST_SCALE);
      cmd.emit    = (state_ff == ST_EMIT) && out_free;
   end

   // Sequencer for one crossing: products, divider load, divide, law, scale, emit.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && status.fire) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIV;
            step_in  = '0;
         end
         ST_DIV: begin
            if (step_ff == STEP_WIDTH'(DIV_STEPS - 1)) begin
               state_in = ST_LAW;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_LAW: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // The result register stays full until the receiving side takes it.
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_fire_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.capture && status.fire |=> state_ff == ST_MUL)
      else $error("crossing sample did not start the sequence");

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_DIV |-> step_ff == '0)
      else $error("divider step count left nonzero outside the divide");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted result not presented");
`endif

endmodule

FILE: src/spe_datapath.sv
module spe_datapath #(
   parameter int COUNT_WIDTH = spe_pkg::COUNT_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  spe_pkg::req_type    req_data,
   input  spe_pkg::cmd_type    cmd,
   output spe_pkg::status_type status,
   output spe_pkg::rsp_type    rsp_data
);
   import spe_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Running peaks, arming flag and sample count.
   logic signed [AC_WIDTH-1:0] red_hi_ff, red_hi_in;
   logic signed [AC_WIDTH-1:0] red_lo_ff, red_lo_in;
   logic signed [AC_WIDTH-1:0] ir_hi_ff, ir_hi_in;
   logic signed [AC_WIDTH-1:0] ir_lo_ff, ir_lo_in;
   logic                       armed_ff, armed_in;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [AC_WIDTH-1:0]        ptp_red_in, ptp_ir_in;

   // Operands captured with the crossing sample.
   logic [AC_WIDTH-1:0]    ptp_red_ff, ptp_ir_ff;
   logic [DC_WIDTH-1:0]    dc_red_ff, dc_ir_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff;

   // Products and divider state.
   logic [PROD_WIDTH-1:0]  pr_ff, pr_in;
   logic [PROD_WIDTH-1:0]  den_ff, den_in;
   logic                   dcz_ff, cz_ff, sat_ff;
   logic [PROD_WIDTH-1:0]  rem_ff, rem_in;
   logic [PROD_WIDTH:0]    rem_sh;
   logic                   rem_ge;
   logic [RATIO_WIDTH-1:0] num_lo_ff;
   logic [RATIO_WIDTH-1:0] q_ff;
   logic [COUNT_WIDTH-1:0] prem_ff, prem_in;
   logic [COUNT_WIDTH:0]   prem_sh;
   logic                   prem_ge;
   logic [DIV_STEPS-1:0]   pnum_ff;
   logic [DIV_STEPS-1:0]   pq_ff;

   // SpO2 law and scaling.
   logic [RATIO_WIDTH-1:0]       ratio;
   logic                         law_lo;
   logic [LAW_WIDTH-1:0]         law_base, law_slope, law_x_in;
   logic [LAW_WIDTH-1:0]         law_x_ff;
   logic                         law_lo_ff;
   logic [PULSE_WIDTH-1:0]       pulse_ff;
   logic [LAW_WIDTH-1:0]         mag;
   logic [MAG_Q_WIDTH-1:0]       mag_q;
   logic [SCALE_WIDTH-1:0]       scale_prod_ff, scale_prod_in;
   logic                         neg_ff, lo_ff;
   logic [SPO2_WIDTH-1:0]        spo2_lo_ff;

   // Averaging and result.
   logic [SPO2_WIDTH-1:0]  hi_q, spo2;
   logic [SPO2_WIDTH:0]    spo2_sum, spo2_rnd;
   logic [PULSE_WIDTH:0]   pulse_sum;
   logic [SPO2_WIDTH-1:0]  last_spo2_ff;
   logic [PULSE_WIDTH-1:0] last_pulse_ff;
   rsp_type                rsp_data_ff;

   // A positive red value after arming marks the crossing.
   assign status.fire = armed_ff && !req_data.ac_red[AC_WIDTH-1] && (req_data.ac_red != '0);

   // Peaks include the current sample before the crossing is evaluated.
   always_comb begin
      red_hi_in  = (req_data.ac_red >= red_hi_ff) ? req_data.ac_red : red_hi_ff;
      red_lo_in  = (req_data.ac_red <= red_lo_ff) ? req_data.ac_red : red_lo_ff;
      ir_hi_in   = (req_data.ac_ir >= ir_hi_ff) ? req_data.ac_ir : ir_hi_ff;
      ir_lo_in   = (req_data.ac_ir <= ir_lo_ff) ? req_data.ac_ir : ir_lo_ff;
      ptp_red_in = AC_WIDTH'(red_hi_in - red_lo_in);
      ptp_ir_in  = AC_WIDTH'(ir_hi_in - ir_lo_in);
   end

   // Arming and the saturating period count.
   always_comb begin
      armed_in = armed_ff;
      count_in = count_ff;
      if (status.fire) begin
         armed_in = 1'b0;
         count_in = '0;
      end else begin
         if (req_data.ac_red[AC_WIDTH-1]) begin
            armed_in = 1'b1;
         end
         if (count_ff != COUNT_MAX) begin
            count_in = COUNT_WIDTH'(count_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_hi_ff <= AC_WIDTH'(1);
         red_lo_ff <= '0;
         ir_hi_ff  <= AC_WIDTH'(1);
         ir_lo_ff  <= '0;
         armed_ff  <= 1'b0;
         count_ff  <= '0;
      end else if (cmd.capture) begin
         red_hi_ff <= red_hi_in;
         red_lo_ff <= red_lo_in;
         ir_hi_ff  <= ir_hi_in;
         ir_lo_ff  <= ir_lo_in;
         armed_ff  <= armed_in;
         count_ff  <= count_in;
      end
   end

   // Products for the ratio numerator and denominator.
   assign pr_in  = {{DC_WIDTH{1'b0}}, ptp_red_ff} * {{AC_WIDTH{1'b0}}, dc_ir_ff};
   assign den_in = {{DC_WIDTH{1'b0}}, ptp_ir_ff} * {{AC_WIDTH{1'b0}}, dc_red_ff};

   // One restoring step for the ratio and one for the pulse period.
   always_comb begin
      rem_sh  = {rem_ff, num_lo_ff[RATIO_WIDTH-1]};
      rem_ge  = (rem_sh >= {1'b0, den_ff});
      rem_in  = rem_ge ? PROD_WIDTH'(rem_sh - {1'b0, den_ff}) : rem_sh[PROD_WIDTH-1:0];
      prem_sh = {prem_ff, pnum_ff[DIV_STEPS-1]};
      prem_ge = (prem_sh >= {1'b0, cnt_ff});
      prem_in = prem_ge ? COUNT_WIDTH'(prem_sh - {1'b0, cnt_ff}) : prem_sh[COUNT_WIDTH-1:0];
   end

   // Affine law on the saturated ratio; both branches share one multiplier.
   always_comb begin
      ratio     = sat_ff ? RATIO_MAX : q_ff;
      law_lo    = (ratio[RATIO_WIDTH-1:FRAC_BITS] == '0);
      law_base  = law_lo ? LAW_WIDTH'(LAW_LO_BASE) : LAW_WIDTH'(LAW_HI_BASE);
      law_slope = law_lo ? LAW_WIDTH'(LAW_LO_SLOPE) : LAW_WIDTH'(LAW_HI_SLOPE);
      law_x_in  = LAW_WIDTH'(law_base
                  - law_slope * {{(LAW_WIDTH - RATIO_WIDTH){1'b0}}, ratio});
   end

   // Magnitude over 8192, then times the reciprocal of five.
   always_comb begin
      mag           = law_x_ff[LAW_WIDTH-1] ? LAW_WIDTH'(-law_x_ff) : law_x_ff;
      mag_q         = mag[LAW_WIDTH-2:HI_SHIFT];
      scale_prod_in = {{RECIP_WIDTH{1'b0}}, mag_q}
                      * {{MAG_Q_WIDTH{1'b0}}, RECIP_WIDTH'(RECIP)};
   end

   // Final SpO2 and the averages, truncated toward zero.
   always_comb begin
      hi_q      = SPO2_WIDTH'(scale_prod_ff >> RECIP_SHIFT);
      spo2      = lo_ff ? spo2_lo_ff : (neg_ff ? SPO2_WIDTH'(-hi_q) : hi_q);
      spo2_sum  = {spo2[SPO2_WIDTH-1], spo2} + {last_spo2_ff[SPO2_WIDTH-1], last_spo2_ff};
      spo2_rnd  = spo2_sum + {{SPO2_WIDTH{1'b0}}, spo2_sum[SPO2_WIDTH]};
      pulse_sum = {1'b0, pulse_ff} + {1'b0, last_pulse_ff};
   end

   // Operand capture and the multi-cycle arithmetic.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ptp_red_ff <= ptp_red_in;
         ptp_ir_ff  <= ptp_ir_in;
         dc_red_ff  <= req_data.dc_red;
         dc_ir_ff   <= req_data.dc_ir;
         cnt_ff     <= count_ff;
      end
      if (cmd.mul) begin
         pr_ff  <= pr_in;
         den_ff <= den_in;
         dcz_ff <= (dc_red_ff == '0);
         cz_ff  <= (cnt_ff == '0);
      end
      if (cmd.load) begin
         sat_ff    <= dcz_ff || ({{SAT_SHIFT{1'b0}}, pr_ff} >= {den_ff, {SAT_SHIFT{1'b0}}});
         rem_ff    <= PROD_WIDTH'(pr_ff >> SAT_SHIFT);
         num_lo_ff <= {pr_ff[SAT_SHIFT-1:0], {FRAC_BITS{1'b0}}};
         q_ff      <= '0;
         prem_ff   <= '0;
         pnum_ff   <= DIV_STEPS'(PULSE_NUM);
         pq_ff     <= '0;
      end
      if (cmd.step) begin
         rem_ff    <= rem_in;
         num_lo_ff <= {num_lo_ff[RATIO_WIDTH-2:0], 1'b0};
         q_ff      <= {q_ff[RATIO_WIDTH-2:0], rem_ge};
         prem_ff   <= prem_in;
         pnum_ff   <= {pnum_ff[DIV_STEPS-2:0], 1'b0};
         pq_ff     <= {pq_ff[DIV_STEPS-2:0], prem_ge};
      end
      if (cmd.law) begin
         law_x_ff  <= law_x_in;
         law_lo_ff <= law_lo;
         pulse_ff  <= cz_ff ? PULSE_WIDTH'(PULSE_NUM) : pq_ff[PULSE_WIDTH-1:0];
      end
      if (cmd.scale) begin
         scale_prod_ff <= scale_prod_in;
         neg_ff        <= law_x_ff[LAW_WIDTH-1];
         lo_ff         <= law_lo_ff;
         spo2_lo_ff    <= SPO2_WIDTH'(law_x_ff >> FRAC_BITS);
      end
      if (cmd.emit) begin
         rsp_data_ff.spo2_avg  <= spo2_rnd[SPO2_WIDTH:1];
         rsp_data_ff.pulse_avg <= pulse_sum[PULSE_WIDTH:1];
      end
   end

   // Previous period values for averaging.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_spo2_ff  <= '0;
         last_pulse_ff <= '0;
      end else if (cmd.emit) begin
         last_spo2_ff  <= spo2;
         last_pulse_ff <= pulse_ff;
      end
   end

   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_fire_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.capture && status.fire |=> count_ff == '0 && !armed_ff)
      else $error("crossing did not clear the count and disarm");

   a_peak_signs: assert property (@(posedge clock) disable iff (reset)
      !red_hi_ff[AC_WIDTH-1] && red_hi_ff != '0 && !ir_hi_ff[AC_WIDTH-1] && ir_hi_ff != '0
      && (red_lo_ff[AC_WIDTH-1] || red_lo_ff == '0) && (ir_lo_ff[AC_WIDTH-1] || ir_lo_ff == '0))
      else $error("running peaks left their sign range");

   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_data_ff.pulse_avg <= PULSE_WIDTH'(PULSE_NUM))
      else $error("averaged pulse above its bound");
`endif

endmodule

FILE: src/spo2_pulse_estimator.sv
// Pulse oximeter estimator using the ratio-of-ratios method. Each sample transaction updates
// running red and infrared AC peaks (never cleared) and a period count that saturates at
// 2^COUNT_WIDTH - 1; a sample that does not complete a crossing is taken without a stall. A red
// AC value that turns positive after a negative one produces one result transaction: SpO2
// from a two-piece law on the Q4.12 ratio (saturating at 65535, also for zero red DC) and
// pulse as 30000 / count, each averaged with the previous period. A crossing sample is
// captured, and the input then stays stalled through the operand products, the divider load,
// the bit-serial divide that forms ratio and pulse quotients together, the law multiply, the
// reciprocal scale and the averaging into the output register, and further while a previous
// result has not yet been taken.
module spo2_pulse_estimator #(
   parameter int COUNT_WIDTH = spe_pkg::COUNT_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spe_pkg::rsp_type rsp_data
);
   import spe_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: handshakes and step commands.
   spe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Peaks, divider, SpO2 law and result register.
   spe_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
